[hdl/rk4pd_pkg.sv]
// Package for the RK4 projectile drag integrator: widths, Q16.32 limits,
// register codes, shared types and the rounding and saturation helpers.
// Depends on nothing; every other file in hdl/ imports it.
package rk4pd_pkg;

  localparam int WORD_BITS    = 48;
  localparam int FRAC_BITS    = 32;
  localparam int REG_BITS     = 47;
  localparam int CNT_BITS     = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int PROD_BITS    = 2 * WORD_BITS;
  localparam int MUL_DIGIT    = 16;
  localparam int MUL_STEPS    = WORD_BITS / MUL_DIGIT;
  localparam int SQRT_STEPS   = WORD_BITS;
  localparam int RK_STAGES    = 4;
  localparam int RK_DIV       = 6;
  localparam int DIV_SHIFT    = WORD_BITS + 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WORD_BITS+1:0] ext_t;
  typedef logic [WORD_BITS-1:0]        umag_t;
  typedef logic [PROD_BITS-1:0]        prod_t;
  typedef logic [PROD_BITS:0]          rprod_t;

  typedef struct packed {
    word_t v;
    logic  c;
  } sres_t;

  typedef struct packed {
    logic go;
    logic op_sqrt;
  } unit_req_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DRAG,
    CFG_STEP,
    CFG_STOP,
    CFG_GRAV
  } cfg_idx_e;

  localparam logic KIND_START = 1'b0;

  localparam word_t WMAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN   = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam umag_t WMAX_U = {1'b0, {(WORD_BITS-1){1'b1}}};

  localparam logic [REG_BITS-1:0] DRAG_RESET = '0;
  localparam logic [REG_BITS-1:0] STEP_RESET = REG_BITS'(64'd42949673);
  localparam logic [REG_BITS-1:0] STOP_RESET = REG_BITS'(64'd42949672960);
  localparam logic [REG_BITS-1:0] GRAV_RESET = REG_BITS'(64'd42133629174);
  localparam logic [REG_BITS-1:0] TIME_MAX   = '1;

  // floor(2^DIV_SHIFT / 6): quotient estimate is exact or one low
  localparam umag_t DIV_RECIP = umag_t'((64'd1 << DIV_SHIFT) / RK_DIV);

  function automatic umag_t mag(word_t x);
    mag = x[WORD_BITS-1] ? umag_t'(-x) : umag_t'(x);
  endfunction

  function automatic sres_t from_mag(rprod_t m, logic neg);
    rprod_t lim;
    rprod_t mm;
    sres_t  r;
    lim = {{(PROD_BITS+1-WORD_BITS){1'b0}}, WMAX_U};
    if (neg) lim = lim + 1'b1;
    r.c = (m > lim);
    mm  = r.c ? lim : m;
    r.v = neg ? word_t'(umag_t'(0) - mm[WORD_BITS-1:0]) : word_t'(mm[WORD_BITS-1:0]);
    return r;
  endfunction

  function automatic sres_t sat(ext_t x);
    sres_t r;
    if (x > ext_t'(WMAX)) begin
      r.v = WMAX;
      r.c = 1'b1;
    end else if (x < ext_t'(WMIN)) begin
      r.v = WMIN;
      r.c = 1'b1;
    end else begin
      r.v = word_t'(x);
      r.c = 1'b0;
    end
    return r;
  endfunction

  // product shifted by FRAC_BITS (or one more), magnitude rounded half up
  function automatic sres_t mul_round(prod_t p, logic half, logic neg);
    rprod_t s;
    s = {1'b0, p} + (rprod_t'(1) << (half ? FRAC_BITS : FRAC_BITS - 1));
    s = half ? (s >> (FRAC_BITS + 1)) : (s >> FRAC_BITS);
    return from_mag(s, neg);
  endfunction

endpackage

[hdl/rk4pd_if.sv]
// Channel interfaces of the RK4 projectile integrator: input items,
// result items and configuration writes. Depends on rk4pd_pkg.
interface rk4pd_in_if import rk4pd_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  kind;
  word_t init_vel_x;
  word_t init_vel_y;
  word_t init_pos_x;
  word_t init_pos_y;
  modport source(output valid, kind, init_vel_x, init_vel_y, init_pos_x, init_pos_y,
                 input ready);
  modport sink(input valid, kind, init_vel_x, init_vel_y, init_pos_x, init_pos_y,
               output ready);
endinterface

interface rk4pd_out_if import rk4pd_pkg::*; ();
  logic                valid;
  logic                ready;
  word_t               vel_x;
  word_t               vel_y;
  word_t               pos_x;
  word_t               pos_y;
  logic [REG_BITS-1:0] sim_time;
  logic [CNT_BITS-1:0] step_number;
  logic                finished;
  logic                saturated;
  modport source(output valid, vel_x, vel_y, pos_x, pos_y, sim_time, step_number,
                 finished, saturated, input ready);
  modport sink(input valid, vel_x, vel_y, pos_x, pos_y, sim_time, step_number,
               finished, saturated, output ready);
endinterface

interface rk4pd_cfg_if import rk4pd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [REG_BITS-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hdl/rk4pd_unit.sv]
// Shared arithmetic unit: 48x48 multiply in 16-bit digit passes and a
// one-bit-per-cycle square root of a 96-bit radicand. Depends on rk4pd_pkg.
module rk4pd_unit import rk4pd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  input  umag_t     opa_i,
  input  umag_t     opb_i,
  input  prod_t     rad_i,
  output logic      done_o,
  output prod_t     prod_o,
  output umag_t     root_o
);

  localparam int UCNT_BITS = $clog2(SQRT_STEPS + 1);
  localparam int REM_BITS  = WORD_BITS + 4;

  logic                 busy_q;
  logic                 done_q;
  logic                 sqrt_q;
  logic [UCNT_BITS-1:0] cnt_q;

  umag_t               a_q;
  umag_t               b_q;
  prod_t               acc_q;
  prod_t               rad_q;
  logic [REM_BITS-1:0] rem_q;
  umag_t               root_q;

  logic [MUL_DIGIT-1:0]           dig;
  logic [WORD_BITS+MUL_DIGIT-1:0] pp;
  prod_t                          acc_nx;
  logic [REM_BITS-1:0]            rem_sh;
  logic [REM_BITS-1:0]            trial;
  logic                           ge;
  logic [REM_BITS-1:0]            rem_nx;
  umag_t                          root_nx;

  always_comb begin
    dig     = b_q[WORD_BITS-1 -: MUL_DIGIT];
    pp      = {{MUL_DIGIT{1'b0}}, a_q} * {{WORD_BITS{1'b0}}, dig};
    acc_nx  = (acc_q << MUL_DIGIT) + PROD_BITS'(pp);
    rem_sh  = {rem_q[REM_BITS-3:0], rad_q[PROD_BITS-1 -: 2]};
    trial   = {{(REM_BITS-WORD_BITS-2){1'b0}}, root_q, 2'b01};
    ge      = (rem_sh >= trial);
    rem_nx  = ge ? (rem_sh - trial) : rem_sh;
    root_nx = {root_q[WORD_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        sqrt_q <= req_i.op_sqrt;
        cnt_q  <= req_i.op_sqrt ? UCNT_BITS'(SQRT_STEPS) : UCNT_BITS'(MUL_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == UCNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      a_q    <= opa_i;
      b_q    <= opb_i;
      acc_q  <= '0;
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      if (sqrt_q) begin
        rem_q  <= rem_nx;
        root_q <= root_nx;
        rad_q  <= rad_q << 2;
      end else begin
        acc_q <= acc_nx;
        b_q   <= b_q << MUL_DIGIT;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
  assign root_o = root_q;

  a_no_reissue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.go |-> !busy_q) else $error("unit started while busy");
  a_go_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.go |=> busy_q) else $error("unit did not start");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done longer than one cycle");

endmodule

[hdl/rk4_projectile_drag_step_core.sv]
// Top level of the RK4 projectile integrator with quadratic drag.
// Depends on rk4pd_pkg, the channel interfaces in rk4pd_if and rk4pd_unit.
//
// A start item, or a step item once time has reached stop_time, goes
// straight to the done state. A working step item runs four derivative
// evaluations of 5 multiplies (on the shared 48x16 digit multiplier) and one
// bit-serial square root, 12 midpoint multiplies, and per state element two
// more multiplies for the h*S/6 update. Input ready is low for that whole
// time; a finished result waits in the output register while the next item
// is accepted.
module rk4_projectile_drag_step_core import rk4pd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rk4pd_in_if.sink    in_i,
  rk4pd_out_if.source out_o,
  rk4pd_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ0, S_SQ1, S_SQRT, S_Q, S_T0, S_T1, S_MID,
    S_U1, S_U2, S_U3, S_UMUL, S_UDIV, S_UFIX, S_TIME, S_DONE
  } state_e;

  state_e              st_q;
  logic                wait_q;
  logic [1:0]          j_q;
  logic [1:0]          i_q;
  logic                clip_q;
  logic                out_valid_q;
  logic [REG_BITS-1:0] drag_q;
  logic [REG_BITS-1:0] step_q;
  logic [REG_BITS-1:0] stop_q;
  logic [REG_BITS-1:0] grav_q;
  logic [REG_BITS-1:0] time_q;
  logic [CNT_BITS-1:0] cnt_q;
  word_t               sv_q [RK_STAGES];

  word_t m_q  [RK_STAGES];
  word_t k1_q [RK_STAGES];
  word_t k2_q [RK_STAGES];
  word_t k3_q [RK_STAGES];
  word_t k4_q [RK_STAGES];
  prod_t n_q;
  umag_t spd_q;
  umag_t q_q;
  umag_t x_q;
  umag_t qe_q;
  word_t s_q;
  logic  neg_q;

  word_t               ovx_q;
  word_t               ovy_q;
  word_t               opx_q;
  word_t               opy_q;
  logic [REG_BITS-1:0] otime_q;
  logic [CNT_BITS-1:0] ostep_q;
  logic                ofin_q;
  logic                osat_q;

  unit_req_t req;
  umag_t     opa;
  umag_t     opb;
  logic      u_done;
  prod_t     u_prod;
  umag_t     u_root;

  logic                in_acc;
  logic                out_load;
  logic                uses_unit;
  logic                fire;
  logic                half;
  logic                neg_sel;
  word_t               kmid;
  sres_t               rnd;
  sres_t               spd_r;
  sres_t               dbl;
  ext_t                add_a;
  ext_t                add_b;
  sres_t               add_r;
  logic                clip_set;
  umag_t               qe6;
  umag_t               rem6;
  umag_t               qfix;
  word_t               incv;
  logic [REG_BITS:0]   tsum;
  logic [WORD_BITS+1:0] grav_x;

  rk4pd_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opa_i  (opa),
    .opb_i  (opb),
    .rad_i  (n_q),
    .done_o (u_done),
    .prod_o (u_prod),
    .root_o (u_root)
  );

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_load = (st_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign fire     = wait_q && u_done;
  assign grav_x   = {{(WORD_BITS+2-REG_BITS){1'b0}}, grav_q};

  always_comb begin
    case (st_q)
      S_SQ0, S_SQ1, S_SQRT, S_Q, S_T0, S_T1, S_MID, S_UMUL, S_UDIV: uses_unit = 1'b1;
      default: uses_unit = 1'b0;
    endcase
    req.go      = uses_unit && !wait_q;
    req.op_sqrt = (st_q == S_SQRT);
  end

  always_comb begin
    case (j_q)
      2'd0:    kmid = k1_q[i_q];
      2'd1:    kmid = k2_q[i_q];
      default: kmid = k3_q[i_q];
    endcase
  end

  always_comb begin
    opa     = '0;
    opb     = '0;
    neg_sel = 1'b0;
    case (st_q)
      S_SQ0: begin
        opa = mag(m_q[0]);
        opb = mag(m_q[0]);
      end
      S_SQ1: begin
        opa = mag(m_q[1]);
        opb = mag(m_q[1]);
      end
      S_Q: begin
        opa = {1'b0, drag_q};
        opb = spd_q;
      end
      S_T0: begin
        opa     = q_q;
        opb     = mag(m_q[0]);
        neg_sel = m_q[0][WORD_BITS-1];
      end
      S_T1: begin
        opa     = q_q;
        opb     = mag(m_q[1]);
        neg_sel = m_q[1][WORD_BITS-1];
      end
      S_MID: begin
        opa     = mag(kmid);
        opb     = {1'b0, step_q};
        neg_sel = kmid[WORD_BITS-1];
      end
      S_UMUL: begin
        opa     = mag(s_q);
        opb     = {1'b0, step_q};
        neg_sel = s_q[WORD_BITS-1];
      end
      S_UDIV: begin
        opa = x_q;
        opb = DIV_RECIP;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  always_comb begin
    half  = (st_q == S_MID) && (j_q != 2'(RK_STAGES - 2));
    rnd   = mul_round(u_prod, half, neg_sel);
    spd_r = from_mag({{(PROD_BITS+1-WORD_BITS){1'b0}}, u_root}, 1'b0);
    dbl   = (st_q == S_U2) ? sat(ext_t'(k2_q[i_q]) + ext_t'(k2_q[i_q]))
                           : sat(ext_t'(k3_q[i_q]) + ext_t'(k3_q[i_q]));
    qe6   = (qe_q << 2) + (qe_q << 1);
    rem6  = x_q - qe6;
    qfix  = (rem6 >= umag_t'(RK_DIV)) ? (qe_q + 1'b1) : qe_q;
    incv  = neg_q ? word_t'(umag_t'(0) - qfix) : word_t'(qfix);
    tsum  = {1'b0, time_q} + {1'b0, step_q};
    add_a = '0;
    add_b = '0;
    case (st_q)
      S_T0: begin
        add_b = -ext_t'($signed(rnd.v));
      end
      S_T1: begin
        add_a = -$signed(grav_x);
        add_b = -ext_t'($signed(rnd.v));
      end
      S_MID: begin
        add_a = ext_t'(sv_q[i_q]);
        add_b = ext_t'($signed(rnd.v));
      end
      S_U1: begin
        add_a = ext_t'(k1_q[i_q]);
        add_b = ext_t'(k4_q[i_q]);
      end
      S_U2, S_U3: begin
        add_a = ext_t'(s_q);
        add_b = ext_t'($signed(dbl.v));
      end
      S_UFIX: begin
        add_a = ext_t'(sv_q[i_q]);
        add_b = ext_t'(incv);
      end
      default: begin
        add_a = '0;
      end
    endcase
    add_r = sat(add_a + add_b);
    case (st_q)
      S_SQRT:             clip_set = fire && spd_r.c;
      S_Q, S_UMUL:        clip_set = fire && rnd.c;
      S_T0, S_T1, S_MID:  clip_set = fire && (rnd.c || add_r.c);
      S_U1, S_UFIX:       clip_set = add_r.c;
      S_U2, S_U3:         clip_set = add_r.c || dbl.c;
      S_TIME:             clip_set = tsum[REG_BITS];
      default:            clip_set = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      wait_q      <= 1'b0;
      j_q         <= '0;
      i_q         <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      drag_q      <= DRAG_RESET;
      step_q      <= STEP_RESET;
      stop_q      <= STOP_RESET;
      grav_q      <= GRAV_RESET;
      time_q      <= '0;
      cnt_q       <= '0;
      for (int e = 0; e < RK_STAGES; e++) sv_q[e] <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_DRAG: drag_q <= cfg_i.data;
          CFG_STEP: step_q <= cfg_i.data;
          CFG_STOP: stop_q <= cfg_i.data;
          CFG_GRAV: grav_q <= cfg_i.data;
          default:  drag_q <= drag_q;
        endcase
      end
      if (clip_set) clip_q <= 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      if (uses_unit) begin
        if (!wait_q) wait_q <= 1'b1;
        else if (u_done) wait_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (in_acc) begin
            clip_q <= 1'b0;
            j_q    <= '0;
            i_q    <= '0;
            if (in_i.kind == KIND_START) begin
              sv_q[0] <= in_i.init_vel_x;
              sv_q[1] <= in_i.init_vel_y;
              sv_q[2] <= in_i.init_pos_x;
              sv_q[3] <= in_i.init_pos_y;
              time_q  <= '0;
              cnt_q   <= '0;
              st_q    <= S_DONE;
            end else begin
              st_q <= (time_q < stop_q) ? S_SQ0 : S_DONE;
            end
          end
        end
        S_SQ0:  if (fire) st_q <= S_SQ1;
        S_SQ1:  if (fire) st_q <= S_SQRT;
        S_SQRT: if (fire) st_q <= S_Q;
        S_Q:    if (fire) st_q <= S_T0;
        S_T0:   if (fire) st_q <= S_T1;
        S_T1: begin
          if (fire) begin
            i_q  <= '0;
            st_q <= (j_q == 2'(RK_STAGES - 1)) ? S_U1 : S_MID;
          end
        end
        S_MID: begin
          if (fire) begin
            if (i_q == 2'(RK_STAGES - 1)) begin
              i_q  <= '0;
              j_q  <= j_q + 1'b1;
              st_q <= S_SQ0;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end
        end
        S_U1:   st_q <= S_U2;
        S_U2:   st_q <= S_U3;
        S_U3:   st_q <= S_UMUL;
        S_UMUL: if (fire) st_q <= S_UDIV;
        S_UDIV: if (fire) st_q <= S_UFIX;
        S_UFIX: begin
          sv_q[i_q] <= add_r.v;
          if (i_q == 2'(RK_STAGES - 1)) begin
            st_q <= S_TIME;
          end else begin
            i_q  <= i_q + 1'b1;
            st_q <= S_U1;
          end
        end
        S_TIME: begin
          time_q <= tsum[REG_BITS] ? TIME_MAX : tsum[REG_BITS-1:0];
          if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
          st_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int e = 0; e < RK_STAGES; e++) m_q[e] <= sv_q[e];
    end
    if (fire && st_q == S_SQ0) n_q <= u_prod;
    if (fire && st_q == S_SQ1) n_q <= n_q + u_prod;
    if (fire && st_q == S_SQRT) spd_q <= umag_t'(spd_r.v);
    if (fire && st_q == S_Q) q_q <= umag_t'(rnd.v);
    if (fire && st_q == S_T0) begin
      case (j_q)
        2'd0:    k1_q[0] <= add_r.v;
        2'd1:    k2_q[0] <= add_r.v;
        2'd2:    k3_q[0] <= add_r.v;
        default: k4_q[0] <= add_r.v;
      endcase
    end
    if (fire && st_q == S_T1) begin
      case (j_q)
        2'd0: begin
          k1_q[1] <= add_r.v;
          k1_q[2] <= m_q[0];
          k1_q[3] <= m_q[1];
        end
        2'd1: begin
          k2_q[1] <= add_r.v;
          k2_q[2] <= m_q[0];
          k2_q[3] <= m_q[1];
        end
        2'd2: begin
          k3_q[1] <= add_r.v;
          k3_q[2] <= m_q[0];
          k3_q[3] <= m_q[1];
        end
        default: begin
          k4_q[1] <= add_r.v;
          k4_q[2] <= m_q[0];
          k4_q[3] <= m_q[1];
        end
      endcase
    end
    if (fire && st_q == S_MID) m_q[i_q] <= add_r.v;
    if (st_q == S_U1 || st_q == S_U2 || st_q == S_U3) s_q <= add_r.v;
    if (fire && st_q == S_UMUL) begin
      x_q   <= mag(rnd.v) + umag_t'(RK_DIV / 2);
      neg_q <= rnd.v[WORD_BITS-1];
    end
    if (fire && st_q == S_UDIV) qe_q <= umag_t'(u_prod >> DIV_SHIFT);
    if (out_load) begin
      ovx_q   <= sv_q[0];
      ovy_q   <= sv_q[1];
      opx_q   <= sv_q[2];
      opy_q   <= sv_q[3];
      otime_q <= time_q;
      ostep_q <= cnt_q;
      ofin_q  <= (time_q >= stop_q);
      osat_q  <= clip_q;
    end
  end

  assign in_i.ready        = (st_q == S_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.vel_x       = ovx_q;
  assign out_o.vel_y       = ovy_q;
  assign out_o.pos_x       = opx_q;
  assign out_o.pos_y       = opy_q;
  assign out_o.sim_time    = otime_q;
  assign out_o.step_number = ostep_q;
  assign out_o.finished    = ofin_q;
  assign out_o.saturated   = osat_q;

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == S_DONE)) else $error("result not from done");
  a_clip_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !clip_q) else $error("clip flag not cleared on new item");
  a_no_wait_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE || st_q == S_DONE) |-> !wait_q) else $error("stale unit wait");

endmodule

[bench/tb_rk4_projectile_drag_step_core.sv]
// Self-checking bench for rk4_projectile_drag_step_core: directed and random items over several
// register settings, checked against a bit-exact fixed-point RK4 predictor.
// Depends on rk4pd_pkg, the channel interfaces in rk4pd_if and the core itself.
module tb_rk4_projectile_drag_step_core;
  import rk4pd_pkg::*;

  localparam longint QMAX  = 64'sd140737488355327;
  localparam longint QMIN  = -QMAX - 1;
  localparam int     STALL = 20000;
  localparam int     HOLD  = 1500;

  typedef longint vec_t [4];

  typedef struct {
    logic  kind;
    word_t vx, vy, px, py;
  } shot_t;

  typedef struct {
    word_t               vx, vy, px, py;
    logic [REG_BITS-1:0] tm;
    logic [CNT_BITS-1:0] n;
    logic                fin, sat;
  } state_t;

  logic clk_i;
  logic rst_ni;

  rk4pd_in_if  in_if ();
  rk4pd_out_if out_if ();
  rk4pd_cfg_if cfg_if ();

  rk4_projectile_drag_step_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  shot_t  shot_q [$];
  state_t due_q [$];
  shot_t  cur;
  int     errors;
  int     idle_cyc;
  int     cyc;
  int     hold_cnt;
  bit     hold_arm, hold_done;
  bit     in_took;
  bit     run;
  bit     calm;
  bit     clipped;

  longint k_drag, h_step, t_stop, g_acc;
  longint pv [4];
  longint p_time;
  logic [31:0] p_cnt;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------- fixed-point predictor ----------------
  function automatic logic [96:0] mag97(longint a);
    return a < 0 ? 97'(-a) : 97'(a);
  endfunction

  function automatic longint to_word(logic [96:0] m, bit neg);
    logic [96:0] lim;
    lim = neg ? (97'(1) << 47) : (97'(1) << 47) - 97'(1);
    if (m > lim) begin
      clipped = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint wclip(longint x);
    if (x > QMAX) begin
      clipped = 1'b1;
      return QMAX;
    end
    if (x < QMIN) begin
      clipped = 1'b1;
      return QMIN;
    end
    return x;
  endfunction

  function automatic longint mul_rnd(longint a, longint b, int s);
    logic [96:0] p;
    p = mag97(a) * mag97(b);
    p = (p + (97'(1) << (s - 1))) >> s;
    return to_word(p, (a < 0) != (b < 0));
  endfunction

  function automatic logic [63:0] speed_root(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= n) r = c;
    end
    return r;
  endfunction

  function automatic void slope(input vec_t y, output vec_t d);
    logic [127:0] n;
    longint spd, q;
    n   = 128'(mag97(y[0]) * mag97(y[0])) + 128'(mag97(y[1]) * mag97(y[1]));
    spd = to_word(97'(speed_root(n)), 1'b0);
    q   = mul_rnd(k_drag, spd, FRAC_BITS);
    d[0] = wclip(0 - mul_rnd(q, y[0], FRAC_BITS));
    d[1] = wclip(wclip(0 - g_acc) - mul_rnd(q, y[1], FRAC_BITS));
    d[2] = y[0];
    d[3] = y[1];
  endfunction

  function automatic void rk4_advance();
    vec_t y, m, d1, d2, d3, d4;
    longint s, inc;
    y = pv;
    slope(y, d1);
    for (int i = 0; i < 4; i++) m[i] = wclip(y[i] + mul_rnd(d1[i], h_step, FRAC_BITS + 1));
    slope(m, d2);
    for (int i = 0; i < 4; i++) m[i] = wclip(y[i] + mul_rnd(d2[i], h_step, FRAC_BITS + 1));
    slope(m, d3);
    for (int i = 0; i < 4; i++) m[i] = wclip(y[i] + mul_rnd(d3[i], h_step, FRAC_BITS));
    slope(m, d4);
    for (int i = 0; i < 4; i++) begin
      s   = wclip(d1[i] + d4[i]);
      s   = wclip(s + wclip(d2[i] + d2[i]));
      s   = wclip(s + wclip(d3[i] + d3[i]));
      inc = mul_rnd(s, h_step, FRAC_BITS);
      inc = to_word((mag97(inc) + 97'd3) / 97'd6, inc < 0);
      pv[i] = wclip(y[i] + inc);
    end
    p_time = p_time + h_step;
    if (p_time > QMAX) begin
      clipped = 1'b1;
      p_time  = QMAX;
    end
    if (p_cnt != '1) p_cnt = p_cnt + 1'b1;
  endfunction

  function automatic state_t project_step(shot_t s);
    state_t r;
    clipped = 1'b0;
    if (s.kind == KIND_START) begin
      pv[0] = longint'(s.vx);
      pv[1] = longint'(s.vy);
      pv[2] = longint'(s.px);
      pv[3] = longint'(s.py);
      p_time = 0;
      p_cnt  = '0;
    end else if (p_time < t_stop) begin
      rk4_advance();
    end
    r.vx  = word_t'(pv[0]);
    r.vy  = word_t'(pv[1]);
    r.px  = word_t'(pv[2]);
    r.py  = word_t'(pv[3]);
    r.tm  = REG_BITS'(p_time);
    r.n   = p_cnt;
    r.fin = p_time >= t_stop;
    r.sat = clipped;
    return r;
  endfunction

  // ---------------- driving and checking ----------------
  always @(posedge clk_i) begin
    cyc  <= cyc + 1;
    calm <= (cyc % 100000) < 25000;
  end

  always @(posedge clk_i) begin
    in_took = in_if.valid && in_if.ready;
    if (in_took) due_q.push_back(project_step(cur));
  end

  always @(negedge clk_i) begin : driver
    logic nv;
    if (run && (!in_if.valid || in_took)) begin
      nv = 1'b0;
      if (shot_q.size() > 0 && (calm || $urandom_range(0, 99) >= 6)) begin
        cur = shot_q.pop_front();
        in_if.kind       <= cur.kind;
        in_if.init_vel_x <= cur.vx;
        in_if.init_vel_y <= cur.vy;
        in_if.init_pos_x <= cur.px;
        in_if.init_pos_y <= cur.py;
        nv = 1'b1;
      end
      in_if.valid <= nv;
    end
  end

  always @(negedge clk_i) begin
    if (run) begin
      if (hold_arm && !hold_done) begin
        hold_cnt  = HOLD;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt = hold_cnt - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || $urandom_range(0, 99) >= 6;
      end
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin : monitor
    state_t e;
    if (out_if.valid && out_if.ready) begin
      if (due_q.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        e = due_q.pop_front();
        if (out_if.vel_x !== e.vx) report("vel_x", out_if.vel_x, e.vx);
        if (out_if.vel_y !== e.vy) report("vel_y", out_if.vel_y, e.vy);
        if (out_if.pos_x !== e.px) report("pos_x", out_if.pos_x, e.px);
        if (out_if.pos_y !== e.py) report("pos_y", out_if.pos_y, e.py);
        if (out_if.sim_time !== e.tm) report("sim_time", out_if.sim_time, e.tm);
        if (out_if.step_number !== e.n) report("step_number", out_if.step_number, e.n);
        if (out_if.finished !== e.fin) report("finished", out_if.finished, e.fin);
        if (out_if.saturated !== e.sat) report("saturated", out_if.saturated, e.sat);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= STALL) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  // ---------------- stimulus ----------------
  task automatic cfg_write(cfg_idx_e idx, logic [REG_BITS-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    case (idx)
      CFG_DRAG: k_drag = longint'(val);
      CFG_STEP: h_step = longint'(val);
      CFG_STOP: t_stop = longint'(val);
      default:  g_acc  = longint'(val);
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_regs(logic [46:0] k, logic [46:0] h, logic [46:0] t, logic [46:0] g);
    cfg_write(CFG_DRAG, k);
    cfg_write(CFG_STEP, h);
    cfg_write(CFG_STOP, t);
    cfg_write(CFG_GRAV, g);
  endtask

  task automatic drain();
    while (shot_q.size() != 0 || in_if.valid || due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic word_t rnd_q();
    longint v;
    int     w;
    case ($urandom_range(0, 5))
      0: return word_t'({$urandom, $urandom});
      1: return $urandom_range(0, 1) ? WMAX : WMIN;
      default: begin
        w = $urandom_range(20, 42);
        v = longint'({$urandom, $urandom} & ((64'd1 << w) - 1));
        return word_t'($urandom_range(0, 1) ? -v : v);
      end
    endcase
  endfunction

  function automatic logic [46:0] rnd_reg(int w);
    return 47'({$urandom, $urandom} & ((64'd1 << w) - 1));
  endfunction

  task automatic push(logic kind, word_t vx, word_t vy, word_t px, word_t py);
    shot_t s;
    s.kind = kind;
    s.vx = vx;
    s.vy = vy;
    s.px = px;
    s.py = py;
    shot_q.push_back(s);
  endtask

  task automatic step(int n);
    repeat (n) push(~KIND_START, rnd_q(), rnd_q(), rnd_q(), rnd_q());
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) push(KIND_START, rnd_q(), rnd_q(), rnd_q(), rnd_q());
      else step(1);
    end
  endtask

  initial begin
    errors = 0;
    idle_cyc = 0;
    cyc = 0;
    calm = 1'b0;
    hold_cnt = 0;
    hold_arm = 1'b0;
    hold_done = 1'b0;
    in_took = 1'b0;
    run = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = 1'b0;
    in_if.init_vel_x = '0;
    in_if.init_vel_y = '0;
    in_if.init_pos_x = '0;
    in_if.init_pos_y = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_DRAG;
    cfg_if.data = '0;
    k_drag = longint'(DRAG_RESET);
    h_step = longint'(STEP_RESET);
    t_stop = longint'(STOP_RESET);
    g_acc  = longint'(GRAV_RESET);
    for (int i = 0; i < 4; i++) pv[i] = 0;
    p_time = 0;
    p_cnt = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run = 1'b1;

    // reset settings: step from zero state, extremes, bit patterns
    step(2);
    push(KIND_START, 48'sd429496729600, 48'sd214748364800, '0, '0);
    step(3);
    push(KIND_START, WMAX, WMAX, WMAX, WMAX);
    step(2);
    push(KIND_START, WMIN, WMIN, WMIN, WMIN);
    step(2);
    push(KIND_START, 48'sh555555555555, 48'shAAAAAAAAAAAA, 48'sh0F0F0F0F0F0F, 48'shF0F0F0F0F0F0);
    step(1);
    push(KIND_START, '0, '0, '0, '0);
    step(1);
    drain();

    // moderate drag, short flights that finish
    set_regs(47'h4000_0000, 47'd214748365, 47'd8589934592, 47'(GRAV_RESET));
    push(KIND_START, 48'sd85899345920, 48'sd85899345920, '0, '0);
    random_run(180);
    drain();

    // everything at its maximum
    set_regs('1, '1, '1, '1);
    push(KIND_START, rnd_q(), rnd_q(), rnd_q(), rnd_q());
    random_run(140);
    drain();

    // zero step size and no gravity: counted steps that move nothing
    set_regs(rnd_reg(32), '0, 47'd4294967296, '0);
    push(KIND_START, rnd_q(), rnd_q(), rnd_q(), rnd_q());
    random_run(120);
    drain();

    // time runs past its maximum
    set_regs(rnd_reg(28), 47'h6000_0000_0000, '1, rnd_reg(40));
    push(KIND_START, rnd_q(), rnd_q(), rnd_q(), rnd_q());
    step(3);
    random_run(120);
    drain();

    // stop time zero: every start is already finished
    set_regs(rnd_reg(47), rnd_reg(30), '0, rnd_reg(47));
    random_run(120);
    drain();

    // receiver holds off while items keep coming
    set_regs(rnd_reg(30), 47'd42949673 + rnd_reg(26), 47'd4294967296 + rnd_reg(34), rnd_reg(38));
    push(KIND_START, rnd_q(), rnd_q(), rnd_q(), rnd_q());
    hold_arm = 1'b1;
    random_run(346);
    drain();

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
